/* hw/rtl/pfla_pkg.sv */
// Shared constants and types for the prime field log/exp table ALU.
// No dependencies; every other file of the block imports this package.

package pfla_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32768;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths
  localparam int VAL_W  = 15;
  localparam int SVAL_W = 16;
  localparam int CMD_W  = 3;
  localparam int ERR_W  = 2;

  // Remainder unit: one quotient bit per cycle over a double-width dividend
  localparam int MOD_STEPS = 2 * VAL_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [VAL_W-1:0] PRIME_RESET = 15'd32003;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD    = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SUB      = 3'd2,
    CMD_MUL      = 3'd3,
    CMD_DIV      = 3'd4,
    CMD_INV      = 3'd5,
    CMD_NEG      = 3'd6,
    CMD_CLASSIFY = 3'd7
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_DIV_ZERO  = 2'd1,
    ERR_NOT_BUILT = 2'd2,
    ERR_NO_GEN    = 2'd3
  } err_t;

endpackage

/* hw/rtl/pfla_if.sv */
// Valid/ready channel interfaces for the command and result streams.
// Depends on pfla_pkg for the field widths.

interface pfla_in_if import pfla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] operand_a;
  logic [VAL_W-1:0] operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface pfla_out_if import pfla_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VAL_W-1:0]         value;
  logic signed [SVAL_W-1:0] signed_value;
  logic [ERR_W-1:0]         error_code;
  logic                     greater_zero;
  logic                     is_minus_one;

  modport source (output valid, value, signed_value, error_code, greater_zero, is_minus_one,
                  input ready);
  modport sink   (input valid, value, signed_value, error_code, greater_zero, is_minus_one,
                  output ready);
endinterface

/* hw/rtl/prime_field_log_table_alu.sv */
// Prime field ALU built on exp/log tables, with its sequencer, shared remainder unit
// and the two table memories. Depends on pfla_pkg and the channels in pfla_if.sv.
//
//   channel   dir   handshake              payload
//   in_ch     in    valid/ready            cmd, operand_a, operand_b
//   out_ch    out   valid/ready            value, signed_value, error_code, flags
//   cfg_      in    cfg_wr_en (no wait)    cfg_wr_data = prime
//
// Add, sub, negate and classify finish from the reduced operands; multiply, divide and
// inverse also make two log reads and one exp read, one read port per table memory.
// Each operand at or above the prime is first reduced in the bit-serial remainder unit.
// Build tests trial divisors up to sqrt(p), then walks the powers of each candidate
// root, one table entry per step of the one multiplier and the 30-step remainder unit.
// Reset is synchronous; tables are not cleared. A result waiting on out_ch does not
// block the next transfer in; only its own final load waits for the output register.

module prime_field_log_table_alu import pfla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  pfla_in_if.sink          in_ch,
  pfla_out_if.source       out_ch
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'h00001,
    S_RED_A     = 18'h00002,
    S_RED_B     = 18'h00004,
    S_DISPATCH  = 18'h00008,
    S_LOG_A     = 18'h00010,
    S_LOG_B     = 18'h00020,
    S_POW_ADDR  = 18'h00040,
    S_POW_READ  = 18'h00080,
    S_CHK       = 18'h00100,
    S_TRIAL_SQ  = 18'h00200,
    S_TRIAL_CMP = 18'h00400,
    S_TRIAL_MOD = 18'h00800,
    S_BLD_INIT  = 18'h01000,
    S_BLD_TWO   = 18'h02000,
    S_CAND      = 18'h04000,
    S_STEP_MUL  = 18'h08000,
    S_STEP_MOD  = 18'h10000,
    S_DONE      = 18'h20000
  } state_t;

  // Control state
  state_t state_r, state_nxt;
  logic   tables_ready_r, tables_ready_nxt;
  val_t   prime_r, prime_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Command and working registers
  cmd_t   cmd_r, cmd_nxt;
  val_t   ra_r, ra_nxt, rb_r, rb_nxt;
  val_t   a_r, a_nxt, b_r, b_nxt;
  val_t   la_r, la_nxt;
  val_t   w_r, w_nxt, x_r, x_nxt, i_r, i_nxt;
  logic   gz_r, gz_nxt, m1_r, m1_nxt;
  val_t   res_val_r, res_val_nxt;
  err_t   res_err_r, res_err_nxt;

  // Remainder unit
  logic [MOD_STEPS-1:0] num_r, num_nxt;
  val_t                 rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 md_run;
  logic                 md_last;
  val_t                 md_div;
  logic [VAL_W:0]       md_t;
  logic [VAL_W:0]       md_diff;
  val_t                 md_rem;

  // Shared multiplier
  val_t                 mul_b;
  logic [MOD_STEPS-1:0] mul_p;

  // Output register
  val_t                     out_value_r, out_value_nxt;
  logic signed [SVAL_W-1:0] out_sval_r, out_sval_nxt;
  err_t                     out_err_r, out_err_nxt;
  logic                     out_gz_r, out_gz_nxt, out_m1_r, out_m1_nxt;
  logic                     out_load;
  logic [SVAL_W-1:0]        sv_diff;

  // Table memories
  val_t              pow_mem [TABLE_DEPTH];
  val_t              log_mem [TABLE_DEPTH];
  logic              pow_we, log_we;
  logic [ADDR_W-1:0] pow_wa, log_wa, pow_rd_addr, log_rd_addr;
  val_t              pow_wd, log_wd, pow_q, log_q;

  // Arithmetic helpers
  val_t           pm1;
  logic [VAL_W:0] add_sum, sub_alt, mul_sum, div_alt;
  val_t           add_v, sub_v, neg_v;
  val_t           exp_idx;
  logic           accept;

  assign pm1    = prime_r - VAL_W'(1);
  assign accept = in_ch.valid && in_ch.ready;

  // Bit-serial remainder: shift one dividend bit in, subtract the divisor if it fits
  assign md_run  = state_r inside {S_RED_A, S_RED_B, S_TRIAL_MOD, S_STEP_MOD};
  assign md_last = (cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign md_div  = (state_r == S_TRIAL_MOD) ? w_r : prime_r;
  assign md_t    = {rem_r, num_r[MOD_STEPS-1]};
  assign md_diff = md_t - {1'b0, md_div};
  assign md_rem  = (md_t >= {1'b0, md_div}) ? md_diff[VAL_W-1:0] : md_t[VAL_W-1:0];

  // One multiplier: w*w for the primality test, w*x for table steps
  assign mul_b = (state_r == S_TRIAL_SQ) ? w_r : x_r;
  assign mul_p = MOD_STEPS'(w_r) * MOD_STEPS'(mul_b);

  // Direct field operations on reduced operands
  assign add_sum = {1'b0, a_r} + {1'b0, b_r};
  assign add_v   = (add_sum >= {1'b0, prime_r}) ? VAL_W'(add_sum - {1'b0, prime_r})
                                                : add_sum[VAL_W-1:0];
  assign sub_alt = {1'b0, a_r} + {1'b0, prime_r} - {1'b0, b_r};
  assign sub_v   = (a_r >= b_r) ? (a_r - b_r) : sub_alt[VAL_W-1:0];
  assign neg_v   = (a_r == '0) ? '0 : (prime_r - a_r);

  // Exponent index from the logs; log_q holds log(b) in S_POW_ADDR
  assign mul_sum = {1'b0, la_r} + {1'b0, log_q};
  assign div_alt = {1'b0, la_r} + {1'b0, pm1} - {1'b0, log_q};

  always_comb begin
    case (cmd_r)
      CMD_MUL: begin
        exp_idx = (mul_sum >= {1'b0, pm1}) ? VAL_W'(mul_sum - {1'b0, pm1})
                                           : mul_sum[VAL_W-1:0];
      end
      CMD_DIV: begin
        exp_idx = (la_r >= log_q) ? (la_r - log_q) : div_alt[VAL_W-1:0];
      end
      default: begin
        exp_idx = (la_r == '0) ? '0 : (pm1 - la_r);
      end
    endcase
  end

  assign pow_rd_addr = exp_idx[ADDR_W-1:0];
  assign log_rd_addr = (state_r == S_LOG_A) ? a_r[ADDR_W-1:0] : b_r[ADDR_W-1:0];

  // Centered form of the finished result
  assign sv_diff  = {1'b0, res_val_r} - {1'b0, prime_r};
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    tables_ready_nxt = tables_ready_r;
    prime_nxt        = prime_r;
    cmd_nxt          = cmd_r;
    ra_nxt           = ra_r;
    rb_nxt           = rb_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    la_nxt           = la_r;
    w_nxt            = w_r;
    x_nxt            = x_r;
    i_nxt            = i_r;
    gz_nxt           = gz_r;
    m1_nxt           = m1_r;
    res_val_nxt      = res_val_r;
    res_err_nxt      = res_err_r;
    pow_we           = 1'b0;
    pow_wa           = '0;
    pow_wd           = '0;
    log_we           = 1'b0;
    log_wa           = '0;
    log_wd           = '0;

    // advance the remainder unit
    if (md_run) begin
      rem_nxt = md_rem;
      num_nxt = {num_r[MOD_STEPS-2:0], 1'b0};
      cnt_nxt = cnt_r + MOD_CNT_W'(1);
    end else begin
      rem_nxt = rem_r;
      num_nxt = num_r;
      cnt_nxt = cnt_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_ch.cmd);
          ra_nxt  = in_ch.operand_a;
          rb_nxt  = in_ch.operand_b;
          gz_nxt  = (in_ch.operand_a != '0) && (in_ch.operand_a <= (prime_r >> 1));
          m1_nxt  = (prime_r != '0) && (in_ch.operand_a == pm1) &&
                    (in_ch.operand_a != VAL_W'(1));
          num_nxt = MOD_STEPS'(in_ch.operand_a);
          rem_nxt = '0;
          cnt_nxt = '0;
          if (cmd_t'(in_ch.cmd) == CMD_BUILD) begin
            tables_ready_nxt = 1'b0;
            state_nxt        = S_CHK;
          end else if (!tables_ready_r || (prime_r < VAL_W'(2))) begin
            res_val_nxt = '0;
            res_err_nxt = ERR_NOT_BUILT;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_RED_A;
          end
        end
      end

      // reduce operand a, then load operand b
      S_RED_A: begin
        if ((ra_r < prime_r) || md_last) begin
          a_nxt     = (ra_r < prime_r) ? ra_r : md_rem;
          num_nxt   = MOD_STEPS'(rb_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_RED_B;
        end
      end

      S_RED_B: begin
        if ((rb_r < prime_r) || md_last) begin
          b_nxt     = (rb_r < prime_r) ? rb_r : md_rem;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_val_nxt = '0;
        res_err_nxt = ERR_OK;
        state_nxt   = S_DONE;
        case (cmd_r)
          CMD_ADD: res_val_nxt = add_v;
          CMD_SUB: res_val_nxt = sub_v;
          CMD_NEG: res_val_nxt = neg_v;
          CMD_MUL: begin
            if ((a_r != '0) && (b_r != '0)) begin
              state_nxt = S_LOG_A;
            end
          end
          CMD_DIV: begin
            if (b_r == '0) begin
              res_err_nxt = ERR_DIV_ZERO;
            end else if (a_r != '0) begin
              state_nxt = S_LOG_A;
            end
          end
          CMD_INV: begin
            if (a_r == '0) begin
              res_err_nxt = ERR_DIV_ZERO;
            end else begin
              state_nxt = S_LOG_A;
            end
          end
          default: res_val_nxt = a_r;
        endcase
      end

      S_LOG_A: state_nxt = S_LOG_B;

      S_LOG_B: begin
        la_nxt    = log_q;
        state_nxt = S_POW_ADDR;
      end

      S_POW_ADDR: state_nxt = S_POW_READ;

      S_POW_READ: begin
        res_val_nxt = pow_q;
        res_err_nxt = ERR_OK;
        state_nxt   = S_DONE;
      end

      // primality check by trial division
      S_CHK: begin
        if ((prime_r < VAL_W'(2)) || (32'(prime_r) > TABLE_DEPTH)) begin
          res_val_nxt = '0;
          res_err_nxt = ERR_NO_GEN;
          state_nxt   = S_DONE;
        end else begin
          w_nxt     = VAL_W'(2);
          state_nxt = S_TRIAL_SQ;
        end
      end

      S_TRIAL_SQ: begin
        num_nxt   = mul_p;
        state_nxt = S_TRIAL_CMP;
      end

      S_TRIAL_CMP: begin
        if (num_r > MOD_STEPS'(prime_r)) begin
          state_nxt = S_BLD_INIT;
        end else begin
          num_nxt   = MOD_STEPS'(prime_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_TRIAL_MOD;
        end
      end

      S_TRIAL_MOD: begin
        if (md_last) begin
          if (md_rem == '0) begin
            res_val_nxt = '0;
            res_err_nxt = ERR_NO_GEN;
            state_nxt   = S_DONE;
          end else begin
            w_nxt     = w_r + VAL_W'(1);
            state_nxt = S_TRIAL_SQ;
          end
        end
      end

      // fixed entries at index zero
      S_BLD_INIT: begin
        pow_we = 1'b1;
        pow_wd = VAL_W'(1);
        log_we = 1'b1;
        if (prime_r == VAL_W'(2)) begin
          state_nxt = S_BLD_TWO;
        end else begin
          w_nxt     = VAL_W'(2);
          state_nxt = S_CAND;
        end
      end

      S_BLD_TWO: begin
        pow_we           = 1'b1;
        pow_wa           = ADDR_W'(1);
        pow_wd           = VAL_W'(1);
        log_we           = 1'b1;
        log_wa           = ADDR_W'(1);
        tables_ready_nxt = 1'b1;
        res_val_nxt      = VAL_W'(1);
        res_err_nxt      = ERR_OK;
        state_nxt        = S_DONE;
      end

      // start the power walk of the next candidate root
      S_CAND: begin
        if (w_r == prime_r) begin
          res_val_nxt = '0;
          res_err_nxt = ERR_NO_GEN;
          state_nxt   = S_DONE;
        end else begin
          log_we    = 1'b1;
          log_wa    = ADDR_W'(1);
          x_nxt     = VAL_W'(1);
          i_nxt     = '0;
          state_nxt = S_STEP_MUL;
        end
      end

      S_STEP_MUL: begin
        num_nxt   = mul_p;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        i_nxt     = i_r + VAL_W'(1);
        state_nxt = S_STEP_MOD;
      end

      // write both tables, then stop on a return to one or a full period
      S_STEP_MOD: begin
        if (md_last) begin
          pow_we = 1'b1;
          pow_wa = i_r[ADDR_W-1:0];
          pow_wd = md_rem;
          log_we = 1'b1;
          log_wa = md_rem[ADDR_W-1:0];
          log_wd = i_r;
          x_nxt  = md_rem;
          if ((md_rem == VAL_W'(1)) && (i_r == pm1)) begin
            tables_ready_nxt = 1'b1;
            res_val_nxt      = w_r;
            res_err_nxt      = ERR_OK;
            state_nxt        = S_DONE;
          end else if ((md_rem == VAL_W'(1)) || (i_r == pm1)) begin
            w_nxt     = w_r + VAL_W'(1);
            state_nxt = S_CAND;
          end else begin
            state_nxt = S_STEP_MUL;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // a new prime drops the tables
    if (cfg_wr_en) begin
      prime_nxt        = cfg_wr_data;
      tables_ready_nxt = 1'b0;
    end
  end

  // Output register: load on a free slot, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_sval_nxt  = out_sval_r;
    out_err_nxt   = out_err_r;
    out_gz_nxt    = out_gz_r;
    out_m1_nxt    = out_m1_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_val_r;
      out_sval_nxt  = (res_val_r > (prime_r >> 1)) ? $signed(sv_diff)
                                                   : $signed({1'b0, res_val_r});
      out_err_nxt   = res_err_r;
      out_gz_nxt    = gz_r;
      out_m1_nxt    = m1_r;
    end
  end

  assign in_ch.ready         = rst_n && (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.signed_value = out_sval_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.greater_zero = out_gz_r;
  assign out_ch.is_minus_one = out_m1_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tables_ready_r <= 1'b0;
      prime_r        <= PRIME_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      tables_ready_r <= tables_ready_nxt;
      prime_r        <= prime_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    la_r        <= la_nxt;
    w_r         <= w_nxt;
    x_r         <= x_nxt;
    i_r         <= i_nxt;
    gz_r        <= gz_nxt;
    m1_r        <= m1_nxt;
    res_val_r   <= res_val_nxt;
    res_err_r   <= res_err_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
    out_sval_r  <= out_sval_nxt;
    out_err_r   <= out_err_nxt;
    out_gz_r    <= out_gz_nxt;
    out_m1_r    <= out_m1_nxt;
  end

  // Exp table
  always_ff @(posedge clk) begin
    if (pow_we) begin
      pow_mem[pow_wa] <= pow_wd;
    end
    pow_q <= pow_mem[pow_rd_addr];
  end

  // Log table
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_wa] <= log_wd;
    end
    log_q <= log_mem[log_rd_addr];
  end

  // Tables become ready only at the end of a build
  a_ready_from_build: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tables_ready_r) |-> ($past(state_r) == S_STEP_MOD || $past(state_r) == S_BLD_TWO))
    else $error("tables_ready set outside a build");

  // A prime write always invalidates the tables
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !tables_ready_r)
    else $error("tables_ready survived a prime write");

  // A transfer in starts work at once
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("transfer in did not start the sequencer");

  // With valid tables every exp lookup stays inside the field
  a_exp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POW_ADDR && tables_ready_r) |-> (exp_idx < prime_r))
    else $error("exp index out of field range");

endmodule

/* tb/sv/pfla_field_checker.sv */
`timescale 1ns / 1ps
// Result checker for the prime field ALU: watches the register port and both channels,
// predicts each result from its own field tables and compares. Depends on pfla_pkg, pfla_if.

module pfla_field_checker import pfla_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  pfla_in_if               in_mon,
  pfla_out_if              out_mon,
  output int unsigned      mismatch_count,
  output int unsigned      results_pending
);

  typedef struct packed {
    logic [VAL_W-1:0]         value;
    logic signed [SVAL_W-1:0] signed_value;
    logic [ERR_W-1:0]         error_code;
    logic                     greater_zero;
    logic                     is_minus_one;
  } alu_result_t;

  // Field state as the block should hold it
  int unsigned field_p   = PRIME_RESET;
  bit          tables_ok = 1'b0;
  val_t        power_mem [TABLE_DEPTH];
  val_t        log_mem   [TABLE_DEPTH];
  alu_result_t pending_results[$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  task automatic log_mismatch(string msg);
    $display("[%0t] result mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [SVAL_W-1:0] got, logic [SVAL_W-1:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic bit is_prime_value(int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Search roots from 2 upward, leaving the tables as the last full walk wrote them
  function automatic bit build_field_tables(int unsigned n);
    int unsigned w, i, x;
    power_mem[0] = 15'd1;
    log_mem[0]   = 15'd0;
    if (n == 2) begin
      power_mem[1] = 15'd1;
      log_mem[1]   = 15'd0;
      return 1'b1;
    end
    for (w = 2; w < n; w++) begin
      log_mem[1] = 15'd0;
      x = 1;
      i = 0;
      do begin
        i++;
        x = (w * x) % n;
        power_mem[i] = val_t'(i == 0 ? 0 : x);
        log_mem[x]   = val_t'(i);
      end while (x != 1 && i < n - 1);
      if (x == 1 && i == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic alu_result_t predict_result(cmd_t op, val_t raw_a, val_t raw_b);
    int unsigned a, b, pm1, s, lb, v;
    int          centered;
    err_t        err;
    alu_result_t r;
    v   = 0;
    err = ERR_OK;
    if (op == CMD_BUILD) begin
      tables_ok = 1'b0;
      if (!is_prime_value(field_p) || !build_field_tables(field_p)) begin
        err = ERR_NO_GEN;
      end else begin
        tables_ok = 1'b1;
        v = power_mem[1];
      end
    end else if (!tables_ok || field_p < 2) begin
      err = ERR_NOT_BUILT;
    end else begin
      a   = raw_a % field_p;
      b   = raw_b % field_p;
      pm1 = field_p - 1;
      case (op)
        CMD_ADD: begin
          v = a + b;
          if (v >= field_p) v -= field_p;
        end
        CMD_SUB: v = (a >= b) ? a - b : a + field_p - b;
        CMD_MUL: begin
          if (a != 0 && b != 0) begin
            s = log_mem[a] + log_mem[b];
            if (s >= pm1) s -= pm1;
            v = power_mem[s];
          end
        end
        CMD_DIV: begin
          if (b == 0) begin
            err = ERR_DIV_ZERO;
          end else if (a != 0) begin
            s  = log_mem[a];
            lb = log_mem[b];
            s  = (s >= lb) ? s - lb : s + pm1 - lb;
            v  = power_mem[s];
          end
        end
        CMD_INV: begin
          if (a == 0) begin
            err = ERR_DIV_ZERO;
          end else begin
            s = log_mem[a];
            v = power_mem[(s == 0) ? 0 : pm1 - s];
          end
        end
        CMD_NEG: v = (a == 0) ? 0 : field_p - a;
        default: v = a;
      endcase
    end
    centered = (v > (field_p >> 1)) ? int'(v) - int'(field_p) : int'(v);
    r.value        = v[VAL_W-1:0];
    r.signed_value = centered[SVAL_W-1:0];
    r.error_code   = err;
    r.greater_zero = (raw_a != 0) && (raw_a <= (field_p >> 1));
    r.is_minus_one = (field_p != 0) && (raw_a == field_p - 1) && (raw_a != 1);
    return r;
  endfunction

  // Track the register, retire results against the oldest prediction, queue new ones
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      field_p   = PRIME_RESET;
      tables_ok = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        field_p   = cfg_wr_data;
        tables_ok = 1'b0;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          log_mismatch("result transfer with no prediction waiting");
        end else begin
          want = pending_results.pop_front();
          check_field("value", out_mon.value, want.value);
          check_field("signed_value", out_mon.signed_value, want.signed_value);
          check_field("error_code", out_mon.error_code, want.error_code);
          check_field("greater_zero", out_mon.greater_zero, want.greater_zero);
          check_field("is_minus_one", out_mon.is_minus_one, want.is_minus_one);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(predict_result(cmd_t'(in_mon.cmd), in_mon.operand_a,
                                                 in_mon.operand_b));
      end
    end
    results_pending <= pending_results.size();
  end

endmodule

/* tb/sv/tb_prime_field_log_table_alu.sv */
`timescale 1ns / 1ps
// Top of the prime field ALU testbench: clock, reset, command stimulus, result back-pressure
// and the verdict. Depends on pfla_pkg, pfla_if and pfla_field_checker.

module tb_prime_field_log_table_alu;
  import pfla_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned LONG_STALL  = 400;
  localparam int unsigned END_SETTLE  = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  val_t        cfg_wr_data;
  logic        stall_kick;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned cycle_count = 0;

  pfla_in_if  in_ch ();
  pfla_out_if out_ch ();

  prime_field_log_table_alu dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  pfla_field_checker field_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL prime_field_log_table_alu");
      $finish;
    end
  end

  // Result back-pressure: rotate through stall patterns, hold off long on each kick
  initial begin
    int unsigned hold_left;
    int unsigned pat_count;
    logic        kick_seen;
    hold_left = 0;
    pat_count = 0;
    kick_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pat_count++;
      if (stall_kick != kick_seen) begin
        kick_seen = stall_kick;
        hold_left = LONG_STALL;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pat_count[8:6])
          3'd2:    out_ch.ready <= $urandom_range(1);
          3'd3:    out_ch.ready <= ($urandom_range(3) == 0);
          3'd4:    out_ch.ready <= ($urandom_range(7) != 0);
          3'd5:    out_ch.ready <= pat_count[0];
          3'd6:    out_ch.ready <= ($urandom_range(7) == 0);
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one command and hold it until the transfer
  task automatic send_item(cmd_t op, val_t a, val_t b);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_prime(val_t p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly reduced elements, some boundary values, some raw 15-bit values
  function automatic val_t pick_operand(int unsigned p);
    int unsigned r;
    r = $urandom_range(99);
    if (p < 2 || r < 20) return val_t'($urandom_range(32767));
    if (r < 35) begin
      case ($urandom_range(5))
        0:       return val_t'(0);
        1:       return val_t'(1);
        2:       return val_t'(p - 1);
        3:       return val_t'(p >> 1);
        4:       return val_t'((p >> 1) + 1);
        default: return val_t'(p);
      endcase
    end
    return val_t'($urandom_range(p - 1));
  endfunction

  // Random commands in bursts with random gaps; build_w is the build rate in 64ths
  task automatic run_random(int unsigned p, int count, int unsigned build_w, bit long_stall);
    int   sent;
    int   burst;
    int   gap;
    cmd_t op;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < count; k++) begin
        if (long_stall && sent == count / 2) stall_kick <= ~stall_kick;
        op = ($urandom_range(63) < build_w) ? CMD_BUILD : cmd_t'($urandom_range(1, 7));
        send_item(op, pick_operand(p), pick_operand(p));
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Set the field, probe it unbuilt, build if asked, then run random traffic
  task automatic field_phase(val_t p, int count, int unsigned build_w, bit build_it,
                             bit long_stall);
    write_prime(p);
    run_random(p, 2, 0, 1'b0);
    if (build_it) send_item(CMD_BUILD, pick_operand(p), pick_operand(p));
    run_random(p, count, build_w, long_stall);
    wait_idle();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    stall_kick      <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_CLASSIFY;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset prime, tables never built
    send_item(CMD_CLASSIFY, 15'd16001, 15'd0);
    send_item(CMD_CLASSIFY, 15'd32002, 15'd0);
    send_item(CMD_MUL, 15'd32767, 15'd1);
    wait_idle();

    // Register values below two: no generator, nothing built
    write_prime(15'd0);
    send_item(CMD_BUILD, 15'd0, 15'd0);
    send_item(CMD_ADD, 15'd5, 15'd7);
    wait_idle();
    write_prime(15'd1);
    send_item(CMD_BUILD, 15'd1, 15'd1);
    send_item(CMD_CLASSIFY, 15'd0, 15'd0);
    wait_idle();

    // Smallest field with its fixed table entries
    write_prime(15'd2);
    send_item(CMD_BUILD, 15'd0, 15'd0);
    send_item(CMD_MUL, 15'd1, 15'd1);
    send_item(CMD_DIV, 15'd1, 15'd0);
    send_item(CMD_INV, 15'd0, 15'd0);
    send_item(CMD_INV, 15'd1, 15'd0);
    send_item(CMD_SUB, 15'd0, 15'd1);
    send_item(CMD_NEG, 15'd1, 15'd0);
    send_item(CMD_CLASSIFY, 15'd32767, 15'd32767);
    wait_idle();

    // Mid-size field: zero operands, wrap of log sums, unreduced operands
    write_prime(15'd1019);
    send_item(CMD_BUILD, 15'd0, 15'd0);
    send_item(CMD_MUL, 15'd0, 15'd5);
    send_item(CMD_DIV, 15'd0, 15'd5);
    send_item(CMD_MUL, 15'd1018, 15'd1018);
    send_item(CMD_DIV, 15'd1, 15'd1018);
    send_item(CMD_INV, 15'd1, 15'd0);
    send_item(CMD_ADD, 15'd32767, 15'd32767);
    send_item(CMD_DIV, 15'd32767, 15'd32767);
    send_item(CMD_SUB, 15'd3, 15'd1018);
    send_item(CMD_NEG, 15'd0, 15'd0);
    send_item(CMD_CLASSIFY, 15'd509, 15'd0);
    send_item(CMD_CLASSIFY, 15'd1018, 15'd0);
    wait_idle();

    // Random traffic over several fields, composites and the largest prime unbuilt
    field_phase(15'd3, 120, 2, 1'b1, 1'b0);
    field_phase(15'd7, 150, 2, 1'b1, 1'b0);
    field_phase(15'd17, 150, 2, 1'b1, 1'b0);
    field_phase(15'd101, 200, 1, 1'b1, 1'b1);
    field_phase(15'd1019, 300, 0, 1'b1, 1'b1);
    field_phase(15'd2, 80, 2, 1'b1, 1'b0);
    field_phase(15'd15, 20, 16, 1'b0, 1'b0);
    field_phase(15'd32767, 10, 16, 1'b0, 1'b0);
    field_phase(15'd32749, 20, 0, 1'b0, 1'b0);

    // Catch any stray result before the verdict
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("PASS prime_field_log_table_alu");
    end else begin
      $display("FAIL prime_field_log_table_alu");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pfla_pkg.sv
hw/rtl/pfla_if.sv
hw/rtl/prime_field_log_table_alu.sv
tb/sv/pfla_field_checker.sv
tb/sv/tb_prime_field_log_table_alu.sv
